/* rtl/core/ouart_pkg.sv */
`timescale 1ns / 1ps
// ouart_pkg.sv - shared widths, codes, reset values and types of the UART core.
// No dependencies; ouart_rem, ouart_cfg and the core module import it.
package ouart_pkg;

    localparam int unsigned RING_DEPTH_DEF      = 256;
    localparam int unsigned MAX_THIRD_TICKS_DEF = 1024;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned K_REG_W    = 11;
    localparam int unsigned SIZE_REG_W = 9;
    localparam int unsigned MARGIN_W   = 7;
    localparam int unsigned RX_SHIFT_W = 9;
    localparam int unsigned TX_SHIFT_W = 11;

    // Frame timing in thirds of a bit
    localparam int unsigned RX_ARM_THIRDS   = 27 + 1;
    localparam int unsigned TX_FRAME_THIRDS = 30;
    localparam int unsigned THIRDS_PER_BIT  = 3;
    localparam int unsigned MIN_RING_SIZE   = 3;

    localparam logic [BYTE_W-1:0] BREAK_CHAR = 8'h03;

    localparam logic                  PORT_EN_RST  = 1'b0;
    localparam logic [K_REG_W-1:0]    K_RST        = K_REG_W'(2);
    localparam logic [SIZE_REG_W-1:0] SIZE_RST     = SIZE_REG_W'(256);
    localparam logic                  FLOW_RST     = 1'b0;
    localparam logic [MARGIN_W-1:0]   MARGIN_RST   = MARGIN_W'(8);
    localparam logic                  BREAK_EN_RST = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PORT_EN  = 3'd0,
        REG_K        = 3'd1,
        REG_SIZE     = 3'd2,
        REG_FLOW     = 3'd3,
        REG_MARGIN   = 3'd4,
        REG_BREAK_EN = 3'd5
    } t_reg;

    typedef struct packed {
        logic                port_enable;
        logic                flow_control;
        logic                break_enable;
        logic [MARGIN_W-1:0] flow_margin;
        logic                clear_rings;
        logic                retime;
    } t_cfg_ctl;

endpackage

/* rtl/core/ouart_ram.sv */
`timescale 1ns / 1ps
// ouart_ram.sv - generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ouart_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ouart_rem.sv */
`timescale 1ns / 1ps
// ouart_rem.sv - bit-serial remainder unit, re-derives both countdown phases after a bit
// length change. Depends on ouart_pkg.
module ouart_rem #(
    parameter int unsigned DVD_W = 15,
    parameter int unsigned DIV_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_div,
    input  logic [DVD_W-1:0] i_dvd_a,
    input  logic [DVD_W-1:0] i_dvd_b,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem_a,
    output logic [DIV_W-1:0] o_rem_b
);
    import ouart_pkg::*;

    localparam int unsigned STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dvd_a;
    logic [DVD_W-1:0]  r_dvd_b;
    logic [DIV_W-1:0]  r_rem_a;
    logic [DIV_W-1:0]  r_rem_b;

    function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [DIV_W-1:0] div);
        logic [DIV_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, div}) begin
            return DIV_W'(t - {1'b0, div});
        end
        return t[DIV_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_done) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(DVD_W - 1)) begin
                r_done <= 1'b1;
            end
        end
    end

    // one dividend bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd_a <= i_dvd_a;
            r_dvd_b <= i_dvd_b;
            r_rem_a <= '0;
            r_rem_b <= '0;
        end else if (r_busy && !r_done) begin
            r_rem_a <= rem_step(r_rem_a, r_dvd_a[DVD_W-1], i_div);
            r_rem_b <= rem_step(r_rem_b, r_dvd_b[DVD_W-1], i_div);
            r_dvd_a <= r_dvd_a << 1;
            r_dvd_b <= r_dvd_b << 1;
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_rem_a = r_rem_a;
    assign o_rem_b = r_rem_b;

endmodule

/* rtl/core/ouart_cfg.sv */
`timescale 1ns / 1ps
// ouart_cfg.sv - configuration registers with range clamping of bit length and ring size.
// Depends on ouart_pkg.
module ouart_cfg #(
    parameter int unsigned RING_DEPTH      = ouart_pkg::RING_DEPTH_DEF,
    parameter int unsigned MAX_THIRD_TICKS = ouart_pkg::MAX_THIRD_TICKS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ouart_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ouart_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output ouart_pkg::t_cfg_ctl                    o_ctl,
    output logic [$clog2(MAX_THIRD_TICKS+1)-1:0]   o_k,
    output logic [$clog2(RING_DEPTH+1)-1:0]        o_size
);
    import ouart_pkg::*;

    localparam int unsigned K_W  = $clog2(MAX_THIRD_TICKS + 1);
    localparam int unsigned SZ_W = $clog2(RING_DEPTH + 1);

    function automatic logic [K_W-1:0] clamp_k(input logic [K_REG_W-1:0] v);
        if (v == '0) begin
            return K_W'(1);
        end
        if (32'(v) > 32'(MAX_THIRD_TICKS)) begin
            return K_W'(MAX_THIRD_TICKS);
        end
        return K_W'(v);
    endfunction

    function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v);
        if (32'(v) < 32'(MIN_RING_SIZE)) begin
            return SZ_W'(MIN_RING_SIZE);
        end
        if (32'(v) > 32'(RING_DEPTH)) begin
            return SZ_W'(RING_DEPTH);
        end
        return SZ_W'(v);
    endfunction

    logic                r_port_en;
    logic [K_W-1:0]      r_k;
    logic [SZ_W-1:0]     r_size;
    logic                r_flow;
    logic [MARGIN_W-1:0] r_margin;
    logic                r_brk_en;
    logic                r_retime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_en <= PORT_EN_RST;
            r_k       <= clamp_k(K_RST);
            r_size    <= clamp_size(SIZE_RST);
            r_flow    <= FLOW_RST;
            r_margin  <= MARGIN_RST;
            r_brk_en  <= BREAK_EN_RST;
            r_retime  <= 1'b0;
        end else begin
            r_retime <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PORT_EN:  r_port_en <= i_cfg_data[0];
                    REG_K: begin
                        r_k      <= clamp_k(i_cfg_data[K_REG_W-1:0]);
                        r_retime <= 1'b1;
                    end
                    REG_SIZE:     r_size   <= clamp_size(i_cfg_data[SIZE_REG_W-1:0]);
                    REG_FLOW:     r_flow   <= i_cfg_data[0];
                    REG_MARGIN:   r_margin <= i_cfg_data[MARGIN_W-1:0];
                    REG_BREAK_EN: r_brk_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_ctl.port_enable  = r_port_en;
        o_ctl.flow_control = r_flow;
        o_ctl.break_enable = r_brk_en;
        o_ctl.flow_margin  = r_margin;
        o_ctl.clear_rings  = i_cfg_we && (i_cfg_index == REG_SIZE);
        o_ctl.retime       = r_retime;
    end

    assign o_k    = r_k;
    assign o_size = r_size;

endmodule

/* rtl/core/oversampled_uart_with_ring_fifos_core.sv */
`timescale 1ns / 1ps
// One 8N1 UART channel with tick-driven sampler and rx/tx rings held in two RAMs.
// Depends on ouart_pkg, ouart_ram, ouart_rem and ouart_cfg.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one word per operation: a
//   sampling tick with the rx and cts pin levels, a tx byte write, an rx byte read
//   or a status read. Every accepted word yields exactly one result word on the
//   output channel (o_out_valid / i_out_ready) with the popped byte, the write
//   acknowledge, both fill counts, the tx and rts pin levels and the break pulse.
//   A result passes the read stage, which waits for the registered RAM read of
//   the rx ring, and then the output register. The input takes one word per clock
//   while the output does not stall and no phase re-derivation runs. The rings sit
//   in two RAMs with one write and one read port each; pointers, countdowns and
//   shift registers sit in flops. Each countdown keeps its phase within the bit in
//   a separate counter. A write of the bit length re-derives both phases in a
//   bit-serial remainder unit, and the input is held off until that is done.
//   Reset clears all pointers and timers, sets tx and rts high and restores the
//   register defaults; the RAMs are not cleared and need no clearing pass.
//   A stalled output keeps its word; one more result may wait in the read stage,
//   after which o_in_ready drops until the receiver takes the output word.
module oversampled_uart_with_ring_fifos_core #(
    parameter int unsigned RING_DEPTH      = ouart_pkg::RING_DEPTH_DEF,
    parameter int unsigned MAX_THIRD_TICKS = ouart_pkg::MAX_THIRD_TICKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [ouart_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ouart_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ouart_pkg::OP_W-1:0]        i_operation,
    input  logic [ouart_pkg::BYTE_W-1:0]      i_tx_data,
    input  logic                              i_rx_line,
    input  logic                              i_cts_line,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ouart_pkg::BYTE_W-1:0]      o_rx_data,
    output logic                              o_rx_valid,
    output logic                              o_write_accepted,
    output logic [ouart_pkg::CNT_W-1:0]       o_rx_count,
    output logic [ouart_pkg::CNT_W-1:0]       o_tx_count,
    output logic                              o_tx_line,
    output logic                              o_rts_line,
    output logic                              o_break_seen
);
    import ouart_pkg::*;

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam int unsigned SZ_W  = $clog2(RING_DEPTH + 1);
    localparam int unsigned K_W   = $clog2(MAX_THIRD_TICKS + 1);
    localparam int unsigned DIV_W = $clog2(THIRDS_PER_BIT * MAX_THIRD_TICKS + 1);
    localparam int unsigned CD_W  = $clog2(TX_FRAME_THIRDS * MAX_THIRD_TICKS + 1);

    typedef struct packed {
        logic             rx_valid;
        logic             write_accepted;
        logic [CNT_W-1:0] rx_count;
        logic [CNT_W-1:0] tx_count;
        logic             tx_line;
        logic             rts_line;
        logic             break_seen;
    } t_result;

    // Next pointer, wrapping at the ring size in use
    function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                  input logic [SZ_W-1:0] sz);
        logic [SZ_W-1:0] n;
        n = SZ_W'(p) + SZ_W'(1);
        return (n >= sz) ? '0 : PTR_W'(n);
    endfunction

    // Fill level of a ring from its head and tail
    function automatic logic [SZ_W-1:0] ring_fill(input logic [PTR_W-1:0] hd,
                                                  input logic [PTR_W-1:0] tl,
                                                  input logic [SZ_W-1:0] sz);
        return (hd >= tl) ? SZ_W'(hd) - SZ_W'(tl) : SZ_W'(hd) + sz - SZ_W'(tl);
    endfunction

    // ---------------------------------------------------------------- configuration
    t_cfg_ctl         ctl;
    logic [K_W-1:0]   k;
    logic [SZ_W-1:0]  size;
    logic [DIV_W-1:0] div;
    logic [CD_W-1:0]  rx_arm;
    logic [CD_W-1:0]  tx_arm;

    ouart_cfg #(
        .RING_DEPTH      (RING_DEPTH),
        .MAX_THIRD_TICKS (MAX_THIRD_TICKS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (ctl),
        .o_k         (k),
        .o_size      (size)
    );

    // bit period and frame lengths in ticks: constant multiples of k
    assign div    = DIV_W'(k) * DIV_W'(THIRDS_PER_BIT);
    assign rx_arm = CD_W'(k) * CD_W'(RX_ARM_THIRDS);
    assign tx_arm = CD_W'(k) * CD_W'(TX_FRAME_THIRDS);

    // ---------------------------------------------------------------- state
    logic [PTR_W-1:0]      r_rx_head, n_rx_head;
    logic [PTR_W-1:0]      r_rx_tail, n_rx_tail;
    logic [PTR_W-1:0]      r_tx_head, n_tx_head;
    logic [PTR_W-1:0]      r_tx_tail, n_tx_tail;
    logic [CD_W-1:0]       r_rx_cd, n_rx_cd;
    logic [CD_W-1:0]       r_tx_cd, n_tx_cd;
    logic [DIV_W-1:0]      r_rx_rem, n_rx_rem;
    logic [DIV_W-1:0]      r_tx_rem, n_tx_rem;
    logic [RX_SHIFT_W-1:0] r_rx_shift, n_rx_shift;
    logic [TX_SHIFT_W-1:0] r_tx_shift, n_tx_shift;
    logic                  r_tx_pin, n_tx_pin;
    logic                  r_rts, n_rts;
    logic                  r_tx_load, n_tx_load;

    logic [PTR_W-1:0] rx_adv_head, rx_adv_tail, tx_adv_head, tx_adv_tail;
    logic             acc;
    logic             rx_push, rx_pop, tx_push, tx_pop, brk;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    // remainder unit
    logic             rem_busy, rem_done;
    logic [DIV_W-1:0] rem_rx, rem_tx;

    // pipeline
    logic    r_s1_valid;
    t_result r_s1, n_res;
    logic    r_out_valid;
    t_result r_out;
    logic [BYTE_W-1:0] r_out_data;
    logic    s1_adv;

    assign rx_adv_head = ring_adv(r_rx_head, size);
    assign rx_adv_tail = ring_adv(r_rx_tail, size);
    assign tx_adv_head = ring_adv(r_tx_head, size);
    assign tx_adv_tail = ring_adv(r_tx_tail, size);

    // Drain the read stage whenever the output register is free or being taken;
    // refuse words while the bit phases are being re-derived.
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !(rem_busy || ctl.retime) && (!r_s1_valid || s1_adv);
    assign acc        = i_in_valid && o_in_ready;

    ouart_rem #(
        .DVD_W (CD_W),
        .DIV_W (DIV_W)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.retime),
        .i_div   (div),
        .i_dvd_a (r_rx_cd),
        .i_dvd_b (r_tx_cd),
        .o_busy  (rem_busy),
        .o_done  (rem_done),
        .o_rem_a (rem_rx),
        .o_rem_b (rem_tx)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_rx_cd    = r_rx_cd;
        n_tx_cd    = r_tx_cd;
        n_rx_rem   = rem_done ? rem_rx : r_rx_rem;
        n_tx_rem   = rem_done ? rem_tx : r_tx_rem;
        n_rx_shift = r_rx_shift;
        // the tx byte from the registered RAM read arrives now: frame it with start and stop
        n_tx_shift = r_tx_load ? {2'b11, tx_rdata, 1'b0} : r_tx_shift;
        n_tx_pin   = r_tx_pin;
        n_rts      = r_rts;
        n_tx_load  = 1'b0;
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        brk        = 1'b0;

        if (acc) begin
            unique case (i_operation)
                OP_TICK: begin
                    if (ctl.port_enable) begin
                        // receiver: arm on a low line, sample on each bit boundary
                        if (r_rx_cd == '0) begin
                            if (!i_rx_line) begin
                                n_rx_cd    = rx_arm;
                                n_rx_rem   = DIV_W'(k);
                                n_rx_shift = '0;
                            end
                        end else begin
                            n_rx_cd  = r_rx_cd - CD_W'(1);
                            n_rx_rem = (r_rx_rem == '0) ? div - DIV_W'(1)
                                                        : r_rx_rem - DIV_W'(1);
                            if (n_rx_rem == '0) begin
                                if (n_rx_cd == '0) begin
                                    // stop bit high and start bit low: keep the byte
                                    if (i_rx_line && !r_rx_shift[0]) begin
                                        rx_push   = 1'b1;
                                        n_rx_head = rx_adv_head;
                                        brk = ctl.break_enable &&
                                              (r_rx_shift[RX_SHIFT_W-1:1] == BREAK_CHAR);
                                        // full ring: drop the oldest byte
                                        if (rx_adv_head == r_rx_tail) begin
                                            n_rx_tail = rx_adv_tail;
                                        end
                                        if (ctl.flow_control &&
                                            (32'(ring_fill(n_rx_head, n_rx_tail, size)) +
                                             32'(ctl.flow_margin) >= 32'(size))) begin
                                            n_rts = 1'b0;
                                        end
                                    end
                                end else begin
                                    n_rx_shift = {i_rx_line, r_rx_shift[RX_SHIFT_W-1:1]};
                                end
                            end
                        end

                        // transmitter: start a frame when a byte waits and CTS allows
                        if (r_tx_cd == '0) begin
                            if ((r_tx_head != r_tx_tail) &&
                                (!ctl.flow_control || i_cts_line)) begin
                                tx_pop    = 1'b1;
                                n_tx_tail = tx_adv_tail;
                                n_tx_cd   = tx_arm;
                                n_tx_rem  = '0;
                                n_tx_load = 1'b1;
                            end
                        end else begin
                            n_tx_cd  = r_tx_cd - CD_W'(1);
                            n_tx_rem = (r_tx_rem == '0) ? div - DIV_W'(1)
                                                        : r_tx_rem - DIV_W'(1);
                            if (n_tx_rem == '0) begin
                                n_tx_pin   = r_tx_shift[0];
                                n_tx_shift = {1'b0, r_tx_shift[TX_SHIFT_W-1:1]};
                            end
                        end
                    end
                end
                OP_WRITE: begin
                    // refuse the byte when the ring is full
                    if (tx_adv_head != r_tx_tail) begin
                        tx_push   = 1'b1;
                        n_tx_head = tx_adv_head;
                    end
                end
                OP_READ: begin
                    if (ctl.flow_control) begin
                        n_rts = 1'b1;
                    end
                    if (r_rx_head != r_rx_tail) begin
                        rx_pop    = 1'b1;
                        n_rx_tail = rx_adv_tail;
                    end
                end
                default: begin
                    // status read: counts only
                end
            endcase
        end

        // a new ring size empties both rings
        if (ctl.clear_rings) begin
            n_rx_head = '0;
            n_rx_tail = '0;
            n_tx_head = '0;
            n_tx_tail = '0;
        end

        n_res.rx_valid       = rx_pop;
        n_res.write_accepted = tx_push;
        n_res.rx_count       = CNT_W'(ring_fill(n_rx_head, n_rx_tail, size));
        n_res.tx_count       = CNT_W'(ring_fill(n_tx_head, n_tx_tail, size));
        n_res.tx_line        = n_tx_pin;
        n_res.rts_line       = n_rts;
        n_res.break_seen     = brk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head  <= '0;
            r_rx_tail  <= '0;
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_rx_cd    <= '0;
            r_tx_cd    <= '0;
            r_rx_rem   <= '0;
            r_tx_rem   <= '0;
            r_rx_shift <= '0;
            r_tx_shift <= '0;
            r_tx_pin   <= 1'b1;
            r_rts      <= 1'b1;
            r_tx_load  <= 1'b0;
        end else begin
            r_rx_head  <= n_rx_head;
            r_rx_tail  <= n_rx_tail;
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_rx_cd    <= n_rx_cd;
            r_tx_cd    <= n_tx_cd;
            r_rx_rem   <= n_rx_rem;
            r_tx_rem   <= n_tx_rem;
            r_rx_shift <= n_rx_shift;
            r_tx_shift <= n_tx_shift;
            r_tx_pin   <= n_tx_pin;
            r_rts      <= n_rts;
            r_tx_load  <= n_tx_load;
        end
    end

    // ---------------------------------------------------------------- rings
    ouart_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_rx_ring (
        .i_clk   (i_clk),
        .i_we    (rx_push),
        .i_waddr (r_rx_head),
        .i_wdata (r_rx_shift[RX_SHIFT_W-1:1]),
        .i_re    (rx_pop),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    ouart_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .i_clk   (i_clk),
        .i_we    (tx_push),
        .i_waddr (r_tx_head),
        .i_wdata (i_tx_data),
        .i_re    (tx_pop),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    // ---------------------------------------------------------------- result pipeline
    // Read stage: holds the result while the rx RAM read completes. The RAM read
    // data holds until the next pop, which cannot happen before this stage moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.rx_valid ? rx_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rx_data        = r_out_data;
    assign o_rx_valid       = r_out.rx_valid;
    assign o_write_accepted = r_out.write_accepted;
    assign o_rx_count       = r_out.rx_count;
    assign o_tx_count       = r_out.tx_count;
    assign o_tx_line        = r_out.tx_line;
    assign o_rts_line       = r_out.rts_line;
    assign o_break_seen     = r_out.break_seen;

`ifndef SYNTHESIS
    a_no_accept_while_retiming : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_busy |-> !o_in_ready)
        else $error("word accepted while bit phases are re-derived");

    a_tx_load_in_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_load |-> (r_tx_cd != '0))
        else $error("tx byte load outside a running frame");

    a_result_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_rx_valid, o_write_accepted, o_break_seen}))
        else $error("result word flags more than one operation");

    a_ptr_in_ring : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SZ_W'(r_rx_head) < size) && (SZ_W'(r_rx_tail) < size) &&
        (SZ_W'(r_tx_head) < size) && (SZ_W'(r_tx_tail) < size))
        else $error("ring pointer beyond ring size");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb.sv - self-checking bench for the oversampled 8N1 UART core with rx/tx rings.
// Needs ouart_pkg and oversampled_uart_with_ring_fifos_core; holds its own channel model.

import ouart_pkg::*;

// One result word as the output channel presents it
typedef struct packed {
    logic [BYTE_W-1:0] rx_data;
    logic              rx_valid;
    logic              write_accepted;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_count;
    logic              tx_line;
    logic              rts_line;
    logic              break_seen;
} uart_word_t;

// Shadow of the UART channel: registers, rings, timers and pins, plus the
// queue of result words still owed by the core.
class uart_shadow;
    logic                  port_en;
    logic [K_REG_W-1:0]    k_reg;
    logic [SIZE_REG_W-1:0] size_reg;
    logic                  flow_en;
    logic [MARGIN_W-1:0]   margin;
    logic                  brk_en;

    logic [BYTE_W-1:0]     rx_mem [RING_DEPTH_DEF];
    logic [BYTE_W-1:0]     tx_mem [RING_DEPTH_DEF];
    int unsigned           rx_head, rx_tail, tx_head, tx_tail;
    int unsigned           rx_cd, tx_cd;
    logic [RX_SHIFT_W-1:0] rx_sh;
    logic [TX_SHIFT_W-1:0] tx_sh;
    logic                  tx_pin, rts_pin;

    uart_word_t            owed[$];
    int                    errors;

    function new();
        port_en  = PORT_EN_RST;
        k_reg    = K_RST;
        size_reg = SIZE_RST;
        flow_en  = FLOW_RST;
        margin   = MARGIN_RST;
        brk_en   = BREAK_EN_RST;
        rx_head  = 0;
        rx_tail  = 0;
        tx_head  = 0;
        tx_tail  = 0;
        rx_cd    = 0;
        tx_cd    = 0;
        rx_sh    = '0;
        tx_sh    = '0;
        tx_pin   = 1'b1;
        rts_pin  = 1'b1;
        errors   = 0;
    endfunction

    // k clamped to 1..MAX_THIRD_TICKS
    function int unsigned bit_thirds();
        if (k_reg == 0) return 1;
        if (k_reg > MAX_THIRD_TICKS_DEF) return MAX_THIRD_TICKS_DEF;
        return k_reg;
    endfunction

    function int unsigned ring_size();
        if (size_reg < MIN_RING_SIZE) return MIN_RING_SIZE;
        if (size_reg > RING_DEPTH_DEF) return RING_DEPTH_DEF;
        return size_reg;
    endfunction

    function int unsigned next_slot(int unsigned p);
        return (p + 1 >= ring_size()) ? 0 : p + 1;
    endfunction

    function int unsigned fill_level(int unsigned head, int unsigned tail);
        return (head >= tail) ? head - tail : head + ring_size() - tail;
    endfunction

    function void set_reg(t_reg idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_PORT_EN:  port_en = value[0];
            REG_K:        k_reg = value[K_REG_W-1:0];
            REG_SIZE: begin
                // a resize empties both rings
                size_reg = value[SIZE_REG_W-1:0];
                rx_head  = 0;
                rx_tail  = 0;
                tx_head  = 0;
                tx_tail  = 0;
            end
            REG_FLOW:     flow_en = value[0];
            REG_MARGIN:   margin = value[MARGIN_W-1:0];
            REG_BREAK_EN: brk_en = value[0];
            default: ;
        endcase
    endfunction

    // One sampling tick: receiver, then transmitter. Returns the break pulse.
    function logic advance_tick(logic rx, logic cts);
        int unsigned       k, div;
        logic [BYTE_W-1:0] rx_byte;
        logic              brk;
        k   = bit_thirds();
        div = THIRDS_PER_BIT * k;
        brk = 1'b0;

        if (rx_cd == 0) begin
            if (!rx) begin
                rx_cd = RX_ARM_THIRDS * k;
                rx_sh = '0;
            end
        end else begin
            rx_cd--;
            if (rx_cd % div == 0) begin
                if (rx_cd == 0) begin
                    // stop bit high and start bit low: store the byte
                    if (rx && !rx_sh[0]) begin
                        rx_byte = rx_sh[RX_SHIFT_W-1:1];
                        rx_mem[rx_head] = rx_byte;
                        rx_head = next_slot(rx_head);
                        if (brk_en && rx_byte == BREAK_CHAR) brk = 1'b1;
                        if (rx_head == rx_tail) rx_tail = next_slot(rx_tail);
                        if (flow_en && int'(fill_level(rx_head, rx_tail)) >=
                                int'(ring_size()) - int'(margin))
                            rts_pin = 1'b0;
                    end
                end else begin
                    rx_sh = {rx, rx_sh[RX_SHIFT_W-1:1]};
                end
            end
        end

        if (tx_cd == 0) begin
            if (tx_head != tx_tail && (!flow_en || cts)) begin
                tx_sh   = {2'b11, tx_mem[tx_tail], 1'b0};
                tx_tail = next_slot(tx_tail);
                tx_cd   = TX_FRAME_THIRDS * k;
            end
        end else begin
            tx_cd--;
            if (tx_cd % div == 0) begin
                tx_pin = tx_sh[0];
                tx_sh  = tx_sh >> 1;
            end
        end
        return brk;
    endfunction

    // Apply one accepted input word and queue the result word it owes
    function void note_word(t_op op, logic [BYTE_W-1:0] data, logic rx, logic cts);
        uart_word_t w;
        w = '0;
        case (op)
            OP_TICK: if (port_en) w.break_seen = advance_tick(rx, cts);
            OP_WRITE: begin
                if (next_slot(tx_head) != tx_tail) begin
                    tx_mem[tx_head]  = data;
                    tx_head          = next_slot(tx_head);
                    w.write_accepted = 1'b1;
                end
            end
            OP_READ: begin
                if (flow_en) rts_pin = 1'b1;
                if (rx_head != rx_tail) begin
                    w.rx_data  = rx_mem[rx_tail];
                    rx_tail    = next_slot(rx_tail);
                    w.rx_valid = 1'b1;
                end
            end
            default: ;
        endcase
        w.rx_count = CNT_W'(fill_level(rx_head, rx_tail));
        w.tx_count = CNT_W'(fill_level(tx_head, tx_tail));
        w.tx_line  = tx_pin;
        w.rts_line = rts_pin;
        owed.push_back(w);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_word(uart_word_t got);
        uart_word_t want;
        if (owed.size() == 0) begin
            $error("result word arrived with nothing outstanding");
            errors++;
            return;
        end
        want = owed.pop_front();
        compare("rx_data", want.rx_data, got.rx_data);
        compare("rx_valid", want.rx_valid, got.rx_valid);
        compare("write_accepted", want.write_accepted, got.write_accepted);
        compare("rx_count", want.rx_count, got.rx_count);
        compare("tx_count", want.tx_count, got.tx_count);
        compare("tx_line", want.tx_line, got.tx_line);
        compare("rts_line", want.rts_line, got.rts_line);
        compare("break_seen", want.break_seen, got.break_seen);
    endfunction

    function int pending();
        return owed.size();
    endfunction
endclass

module tb;
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation;
    logic [BYTE_W-1:0]     i_tx_data;
    logic                  i_rx_line;
    logic                  i_cts_line;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [BYTE_W-1:0]     o_rx_data;
    logic                  o_rx_valid;
    logic                  o_write_accepted;
    logic [CNT_W-1:0]      o_rx_count;
    logic [CNT_W-1:0]      o_tx_count;
    logic                  o_tx_line;
    logic                  o_rts_line;
    logic                  o_break_seen;

    uart_shadow shadow;

    // Idling knobs, in percent per cycle, and the host access mix per tick
    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   host_pct  = 0;
    int   read_pct  = 0;
    logic cts_level = 1'b1;

    oversampled_uart_with_ring_fifos_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_tx_data        (i_tx_data),
        .i_rx_line        (i_rx_line),
        .i_cts_line       (i_cts_line),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rx_data        (o_rx_data),
        .o_rx_valid       (o_rx_valid),
        .o_write_accepted (o_write_accepted),
        .o_rx_count       (o_rx_count),
        .o_tx_count       (o_tx_count),
        .o_tx_line        (o_tx_line),
        .o_rts_line       (o_rts_line),
        .o_break_seen     (o_break_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: decide backpressure afresh at every falling edge
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Take each result word at the rising edge it is accepted
    always @(posedge i_clk) begin : watch_out
        uart_word_t seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_rx_data, o_rx_valid, o_write_accepted, o_rx_count, o_tx_count,
                    o_tx_line, o_rts_line, o_break_seen};
            shadow.check_word(seen);
        end
    end

    // Offer one input word, idling first at random; return at the accepting edge
    task automatic send_word(input t_op op, input logic [BYTE_W-1:0] data,
                             input logic rx, input logic cts);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99, 0) < gap_pct) gap++;
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_tx_data   <= data;
        i_rx_line   <= rx;
        i_cts_line  <= cts;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_word(op, data, rx, cts);
    endtask

    task automatic hold_input();
        @(negedge i_clk) i_in_valid <= 1'b0;
    endtask

    // Drop valid and wait until every owed result word has come back
    task automatic settle();
        hold_input();
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        shadow.set_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic cfg_release();
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Write the whole register set; the bit length goes last since it holds
    // the input off while the phases are re-derived
    task automatic set_channel(input int unsigned en, input int unsigned k,
                               input int unsigned size, input int unsigned flow,
                               input int unsigned mrg, input int unsigned brk);
        settle();
        write_reg(REG_PORT_EN, en);
        write_reg(REG_SIZE, size);
        write_reg(REG_FLOW, flow);
        write_reg(REG_MARGIN, mrg);
        write_reg(REG_BREAK_EN, brk);
        write_reg(REG_K, k);
        cfg_release();
    endtask

    task automatic host_access();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < read_pct)
            send_word(OP_READ, 8'($urandom()), 1'($urandom()), 1'($urandom()));
        else if (pick < read_pct + (100 - read_pct) * 2 / 3)
            send_word(OP_WRITE, 8'($urandom()), 1'($urandom()), 1'($urandom()));
        else
            send_word(OP_STATUS, 8'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    // One tick at the given rx level; let CTS wander and slip host accesses in
    task automatic send_tick(input logic rx);
        if ($urandom_range(49, 0) == 0) cts_level = ~cts_level;
        send_word(OP_TICK, 8'($urandom()), rx, cts_level);
        if ($urandom_range(99, 0) < host_pct) host_access();
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7, 0))
            0: return BREAK_CHAR;
            1: return 8'h00;
            2: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Drive one 8N1 frame on the rx line, 3*k ticks per bit, then a short idle
    task automatic send_frame(input logic [BYTE_W-1:0] b, input logic stop);
        logic [9:0]  bits;
        int unsigned per_bit;
        bits    = {stop, b, 1'b0};
        per_bit = THIRDS_PER_BIT * shadow.bit_thirds();
        for (int i = 0; i < 10; i++) repeat (per_bit) send_tick(bits[i]);
        repeat ($urandom_range(per_bit, 0)) send_tick(1'b1);
    endtask

    // Hold the line high for a full frame so the receiver is idle again
    task automatic line_quiet();
        repeat (TX_FRAME_THIRDS * shadow.bit_thirds()) send_tick(1'b1);
    endtask

    task automatic run_phase(input int frames, input int gpct, input int spct,
                             input int hpct, input int rpct, input bit pause_mid);
        int kind;
        gap_pct   = gpct;
        stall_pct = spct;
        host_pct  = hpct;
        read_pct  = rpct;
        for (int f = 0; f < frames; f++) begin
            kind = $urandom_range(9, 0);
            if (kind < 8) begin
                send_frame(pick_byte(), 1'b1);
            end else if (kind == 8) begin
                // framing error: low stop bit, drop the byte and let any
                // spurious frame armed by the low line run out
                send_frame(pick_byte(), 1'b0);
                line_quiet();
            end else begin
                // line noise
                repeat ($urandom_range(20, 4)) send_tick(1'($urandom()));
                line_quiet();
            end
            // hold the sender until the core has caught up completely
            if (pause_mid && f == frames / 2) settle();
        end
        settle();
    endtask

    initial begin
        logic [9:0]  slow_frame;
        int unsigned per_bit;

        shadow      = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_PORT_EN;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_operation = OP_STATUS;
        i_tx_data   = '0;
        i_rx_line   = 1'b1;
        i_cts_line  = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: port disabled, so a tick with the line low arms nothing;
        // read the empty ring and write the extreme byte values into the tx ring
        send_word(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_word(OP_READ, 8'hFF, 1'b1, 1'b1);
        send_word(OP_WRITE, 8'h00, 1'b0, 1'b1);
        send_word(OP_WRITE, 8'hFF, 1'b1, 1'b0);
        send_word(OP_STATUS, 8'h5A, 1'b0, 1'b0);
        settle();

        // Undersized ring acts as three: the resize drops the queued bytes,
        // two new ones fit and the third is refused; an empty read still
        // raises RTS under flow control
        write_reg(REG_SIZE, 0);
        write_reg(REG_FLOW, 1);
        write_reg(REG_MARGIN, 0);
        cfg_release();
        send_word(OP_WRITE, 8'hA5, 1'b1, 1'b1);
        send_word(OP_WRITE, 8'h5A, 1'b0, 1'b0);
        send_word(OP_WRITE, 8'h3C, 1'b1, 1'b0);
        send_word(OP_READ, 8'h00, 1'b0, 1'b1);
        send_word(OP_STATUS, 8'hC3, 1'b1, 1'b1);
        settle();

        // Oversized ring saturates; CTS low holds the transmitter, high lets it pop
        write_reg(REG_SIZE, 511);
        write_reg(REG_PORT_EN, 1);
        cfg_release();
        send_word(OP_WRITE, 8'hC3, 1'b1, 1'b1);
        send_word(OP_TICK, 8'h00, 1'b1, 1'b0);
        send_word(OP_TICK, 8'hFF, 1'b1, 1'b1);
        send_word(OP_TICK, 8'h81, 1'b1, 1'b0);
        send_word(OP_STATUS, 8'h7E, 1'b0, 1'b1);
        send_word(OP_READ, 8'h18, 1'b1, 1'b0);
        settle();

        // Bit length changed mid-frame: the countdown runs on and the sample
        // points follow the new length
        host_pct = 0;
        repeat (4) send_tick(1'b1);
        repeat (6) send_tick(1'b0);
        repeat (12) send_tick(1'($urandom()));
        settle();
        write_reg(REG_K, 1);
        cfg_release();
        repeat (30) send_tick(1'($urandom()));
        repeat (30) send_tick(1'b1);

        // Random frames across the settings and idling patterns
        set_channel(1, 1, 5, 1, 1, 1);
        run_phase(6, 0, 0, 30, 15, 1'b0);
        set_channel(1, 2, 256, 0, 8, 0);
        run_phase(3, 46, 0, 20, 50, 1'b1);
        // margin beyond the ring: every stored byte drops RTS
        set_channel(1, 0, 3, 1, 64, 1);
        run_phase(6, 0, 46, 40, 30, 1'b0);
        // flow control off: RTS keeps its last level, CTS ignored
        set_channel(1, 3, 16, 0, 0, 0);
        run_phase(2, 0, 0, 30, 60, 1'b0);
        set_channel(1, 1, 511, 1, 127, 1);
        run_phase(5, 15, 15, 25, 40, 1'b0);

        // Longest bit: one frame each way at k = 1024, then k past the top
        // (saturates to the same length) written half way through
        set_channel(1, 1024, 8, 0, 4, 1);
        gap_pct   = 0;
        stall_pct = 0;
        host_pct  = 0;
        send_word(OP_WRITE, 8'h96, 1'b1, 1'b1);
        slow_frame = {1'b1, BREAK_CHAR, 1'b0};
        per_bit    = THIRDS_PER_BIT * shadow.bit_thirds();
        for (int i = 0; i < 5; i++) repeat (per_bit) send_tick(slow_frame[i]);
        settle();
        write_reg(REG_K, 2047);
        cfg_release();
        for (int i = 5; i < 10; i++) repeat (per_bit) send_tick(slow_frame[i]);
        repeat (per_bit) send_tick(1'b1);
        send_word(OP_STATUS, 8'h00, 1'b1, 1'b1);
        send_word(OP_READ, 8'h00, 1'b1, 1'b1);

        settle();
        repeat (10) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
